// ===== rtl/ssvb_pkg.sv =====
// ssvb_pkg: shared types and constants for the split-screen viewport bounds block.
// Used by ssvb_regs, ssvb_div and the top level; no dependencies.
package ssvb_pkg;

  // Field and datapath widths
  localparam int COORD_W = 16;  // screen coordinates, two's complement
  localparam int SLOT_W  = 5;   // player index after the leftover-slot shift
  localparam int TOTAL_W = 5;   // player count
  localparam int DIM_W   = 3;   // grid rows / columns (at most six)
  localparam int DIV_W   = 16;  // divider dividend / quotient
  localparam int STEP_W  = 5;   // divider step count (up to DIV_W)

  localparam logic [DIM_W-1:0]   MAX_DIM     = 3'd6;
  localparam logic [COORD_W-1:0] GUTTER_PX   = 16'd4;
  localparam logic [STEP_W-1:0]  SLOT_STEPS  = 5'd5;
  localparam logic [STEP_W-1:0]  COORD_STEPS = 5'd16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RENDER_TOP    = 3'd0,
    REG_FRAME_LEFT    = 3'd1,
    REG_RENDER_BOTTOM = 3'd2,
    REG_FRAME_RIGHT   = 3'd3,
    REG_SCREEN_TOP    = 3'd4,
    REG_SCREEN_LEFT   = 3'd5,
    REG_SCREEN_BOTTOM = 3'd6,
    REG_SCREEN_RIGHT  = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_RENDER_TOP    = 16'd0;
  localparam logic [COORD_W-1:0] RST_FRAME_LEFT    = 16'd0;
  localparam logic [COORD_W-1:0] RST_RENDER_BOTTOM = 16'd480;
  localparam logic [COORD_W-1:0] RST_FRAME_RIGHT   = 16'd640;
  localparam logic [COORD_W-1:0] RST_SCREEN_TOP    = 16'd0;
  localparam logic [COORD_W-1:0] RST_SCREEN_LEFT   = 16'd0;
  localparam logic [COORD_W-1:0] RST_SCREEN_BOTTOM = 16'd480;
  localparam logic [COORD_W-1:0] RST_SCREEN_RIGHT  = 16'd640;

  // Request word
  typedef struct packed {
    logic [3:0] player_slot;
    logic [4:0] player_total;
  } req_t;

  // Result word
  typedef struct packed {
    logic signed [15:0] view_top;
    logic signed [15:0] view_left;
    logic signed [15:0] view_bottom;
    logic signed [15:0] view_right;
    logic signed [15:0] safe_top;
    logic signed [15:0] safe_left;
    logic signed [15:0] safe_bottom;
    logic signed [15:0] safe_right;
  } rsp_t;

  // Register file contents
  typedef struct packed {
    logic [COORD_W-1:0] render_top;
    logic [COORD_W-1:0] frame_left;
    logic [COORD_W-1:0] render_bottom;
    logic [COORD_W-1:0] frame_right;
    logic [COORD_W-1:0] screen_top;
    logic [COORD_W-1:0] screen_left;
    logic [COORD_W-1:0] screen_bottom;
    logic [COORD_W-1:0] screen_right;
  } cfg_t;

  // Divider command: dividend left-aligned, steps = number of significant bits
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DIM_W-1:0]  divisor;
  } div_req_t;

  // Divider status and result
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIM_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/ssvb_regs.sv =====
// ssvb_regs: configuration register file (frame and screen rectangles).
// Depends on ssvb_pkg for the register index codes, reset values and cfg_t.
module ssvb_regs import ssvb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output cfg_t               cfg
);

  // Write port, one register per edge
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.render_top    <= RST_RENDER_TOP;
      cfg.frame_left    <= RST_FRAME_LEFT;
      cfg.render_bottom <= RST_RENDER_BOTTOM;
      cfg.frame_right   <= RST_FRAME_RIGHT;
      cfg.screen_top    <= RST_SCREEN_TOP;
      cfg.screen_left   <= RST_SCREEN_LEFT;
      cfg.screen_bottom <= RST_SCREEN_BOTTOM;
      cfg.screen_right  <= RST_SCREEN_RIGHT;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RENDER_TOP:    cfg.render_top    <= cfg_data;
        REG_FRAME_LEFT:    cfg.frame_left    <= cfg_data;
        REG_RENDER_BOTTOM: cfg.render_bottom <= cfg_data;
        REG_FRAME_RIGHT:   cfg.frame_right   <= cfg_data;
        REG_SCREEN_TOP:    cfg.screen_top    <= cfg_data;
        REG_SCREEN_LEFT:   cfg.screen_left   <= cfg_data;
        REG_SCREEN_BOTTOM: cfg.screen_bottom <= cfg_data;
        REG_SCREEN_RIGHT:  cfg.screen_right  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/ssvb_div.sv =====
// ssvb_div: bit-serial restoring divider, one quotient bit per cycle.
// Small divisor (grid dimension); depends on ssvb_pkg for div_req_t / div_rsp_t.
module ssvb_div import ssvb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo;
  logic [DIM_W-1:0]  rem;
  logic [DIM_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIM_W:0]    trial;
  logic              ge;
  logic [DIM_W:0]    diff;
  logic [DIM_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    ge       = (trial >= {1'b0, dvs});
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/split_screen_viewport_bounds.sv =====
// split_screen_viewport_bounds: viewport and safe rectangle of one split-screen player.
// Depends on ssvb_pkg, ssvb_regs (configuration) and ssvb_div (shared divider).
//
// Usage:
//   Request channel (req_valid / req_stall / req_data): one word carries player_slot
//   and player_total. The block stalls the request channel while a word is in work
//   and takes the next word only once the previous result sits in the output register.
//   Result channel (rsp_valid / rsp_stall / rsp_data): one word of eight 16-bit edges,
//   held in an output register until the receiver takes it. A stalled result does not
//   block acceptance of the next request; the sequencer waits in its last step only
//   if a second result is ready before the first has gone.
//   The time from acceptance to rsp_valid grows with the grid search (one step a cycle)
//   and three passes through the bit-serial divider (5, 16 and 16 quotient bits).
//   One word is in work at a time, and the sequencer passes through its idle state
//   after each result before it takes the next word.
//   Configuration: cfg_we writes cfg_data to register cfg_index; write
//   only while no word is in work.
//   Reset (rst, synchronous) restores the default 640x480 frame and screen, empties
//   the output register and returns the sequencer to idle.
module split_screen_viewport_bounds import ssvb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_GRID       = 8'b0000_0010,
    S_SLOT_DIV   = 8'b0000_0100,
    S_WIDTH_DIV  = 8'b0000_1000,
    S_HEIGHT_DIV = 8'b0001_0000,
    S_MAC_T      = 8'b0010_0000,
    S_MAC_L      = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Working registers
  logic [SLOT_W-1:0]  slot;
  logic [TOTAL_W-1:0] total;
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic               span2;
  logic [SLOT_W-1:0]  ri;
  logic [DIM_W-1:0]   ci;
  logic [COORD_W-1:0] cw;
  logic [COORD_W-1:0] ch;
  logic [COORD_W-1:0] vt;
  logic [COORD_W-1:0] vl;

  logic accept;
  logic rsp_load;

  ssvb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssvb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  // Grid test: rows * cols against the player count
  logic [2*DIM_W-1:0] grid_area;
  logic               grid_short;
  logic               grid_over;
  logic [SLOT_W-1:0]  slot_adj;

  always_comb begin
    grid_area  = {{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols};
    grid_short = (grid_area < {1'b0, total});
    grid_over  = (grid_area > {1'b0, total});
    slot_adj   = (grid_over && (slot != '0)) ? slot + 1'b1 : slot;
  end

  // Signed frame extents as magnitude plus sign
  logic [COORD_W:0]   w_diff;
  logic [COORD_W:0]   h_diff;
  logic [COORD_W:0]   w_neg;
  logic [COORD_W:0]   h_neg;
  logic [DIV_W-1:0]   w_mag;
  logic [DIV_W-1:0]   h_mag;
  logic [COORD_W-1:0] q_pos;
  logic [COORD_W-1:0] q_neg;

  always_comb begin
    w_diff = {cfg.frame_right[COORD_W-1], cfg.frame_right}
           - {cfg.frame_left[COORD_W-1], cfg.frame_left};
    h_diff = {cfg.render_bottom[COORD_W-1], cfg.render_bottom}
           - {cfg.render_top[COORD_W-1], cfg.render_top};
    w_neg  = (COORD_W+1)'(0) - w_diff;
    h_neg  = (COORD_W+1)'(0) - h_diff;
    w_mag  = w_diff[COORD_W] ? w_neg[DIV_W-1:0] : w_diff[DIV_W-1:0];
    h_mag  = h_diff[COORD_W] ? h_neg[DIV_W-1:0] : h_diff[DIV_W-1:0];
    q_pos  = div_rsp.quotient;
    q_neg  = COORD_W'(0) - div_rsp.quotient;
  end

  // Divider commands, issued as the grid step and the first two divide steps hand over
  always_comb begin
    div_req = '0;
    case (state)
      S_GRID: begin
        div_req.start    = !grid_short;
        div_req.steps    = SLOT_STEPS;
        div_req.dividend = {slot_adj, {(DIV_W-SLOT_W){1'b0}}};
        div_req.divisor  = cols;
      end
      S_SLOT_DIV: begin
        div_req.start    = div_rsp.done;
        div_req.steps    = COORD_STEPS;
        div_req.dividend = w_mag;
        div_req.divisor  = cols;
      end
      S_WIDTH_DIV: begin
        div_req.start    = div_rsp.done;
        div_req.steps    = COORD_STEPS;
        div_req.dividend = h_mag;
        div_req.divisor  = rows;
      end
      default: begin
      end
    endcase
  end

  // Shared multiply-add: cell size * index + frame origin
  logic [COORD_W-1:0]        mul_a;
  logic [SLOT_W-1:0]         mul_b;
  logic [COORD_W+SLOT_W-1:0] mul_p;
  logic [COORD_W-1:0]        mac;

  always_comb begin
    mul_a = (state == S_MAC_T) ? ch : cw;
    mul_b = (state == S_MAC_T) ? ri : {{(SLOT_W-DIM_W){1'b0}}, ci};
    mul_p = (COORD_W+SLOT_W)'(mul_a) * (COORD_W+SLOT_W)'(mul_b);
    mac   = mul_p[COORD_W-1:0] + ((state == S_MAC_T) ? cfg.render_top : cfg.frame_left);
  end

  // Final edges: far edges, gutter inset, screen-border extension
  logic [COORD_W-1:0] gutter;
  logic [COORD_W-1:0] vb;
  logic [COORD_W-1:0] vr;
  logic               first_row;
  logic               first_col;
  logic               last_row;
  logic               last_col;
  logic [DIM_W:0]     col_end;
  logic [SLOT_W:0]    row_end;
  rsp_t               rsp_next;

  always_comb begin
    gutter    = (total > TOTAL_W'(1)) ? GUTTER_PX : '0;
    vb        = vt + ch;
    vr        = vl + cw;
    first_row = (ri == '0);
    first_col = (ci == '0);
    col_end   = {{DIM_W{1'b0}}, span2} + {1'b0, ci} + 1'b1;
    row_end   = {1'b0, ri} + 1'b1;
    last_col  = (col_end == {1'b0, cols});
    last_row  = (row_end == {{(SLOT_W+1-DIM_W){1'b0}}, rows});

    rsp_next.view_top    = first_row ? cfg.screen_top    : vt;
    rsp_next.view_left   = first_col ? cfg.screen_left   : vl;
    rsp_next.view_bottom = last_row  ? cfg.screen_bottom : vb;
    rsp_next.view_right  = last_col  ? cfg.screen_right  : vr;
    rsp_next.safe_top    = vt + ((total > TOTAL_W'(1)) ?
                           {{(COORD_W-SLOT_W-2){1'b0}}, ri, 2'b00} : COORD_W'(0));
    rsp_next.safe_left   = vl + ((total > TOTAL_W'(1)) ?
                           {{(COORD_W-DIM_W-2){1'b0}}, ci, 2'b00} : COORD_W'(0));
    rsp_next.safe_bottom = vb - (first_row ? gutter : COORD_W'(0));
    rsp_next.safe_right  = vr - (first_col ? gutter : COORD_W'(0));
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE:       if (accept) state <= S_GRID;
        S_GRID:       if (!grid_short) state <= S_SLOT_DIV;
        S_SLOT_DIV:   if (div_rsp.done) state <= S_WIDTH_DIV;
        S_WIDTH_DIV:  if (div_rsp.done) state <= S_HEIGHT_DIV;
        S_HEIGHT_DIV: if (div_rsp.done) state <= S_MAC_T;
        S_MAC_T:      state <= S_MAC_L;
        S_MAC_L:      state <= S_FINISH;
        S_FINISH:     if (rsp_load) state <= S_IDLE;
        default:      state <= S_IDLE;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          slot  <= {1'b0, req_data.player_slot};
          total <= req_data.player_total;
          rows  <= DIM_W'(1);
          cols  <= DIM_W'(1);
          span2 <= 1'b0;
        end
      end
      S_GRID: begin
        if (grid_short) begin
          if (cols < rows) begin
            cols <= cols + 1'b1;
          end else begin
            cols <= DIM_W'(1);
            rows <= rows + 1'b1;
          end
        end else begin
          slot  <= slot_adj;
          span2 <= grid_over && (slot == '0);
        end
      end
      S_SLOT_DIV: begin
        if (div_rsp.done) begin
          ri <= div_rsp.quotient[SLOT_W-1:0];
          ci <= div_rsp.remainder;
        end
      end
      S_WIDTH_DIV: begin
        if (div_rsp.done) begin
          if (w_diff[COORD_W]) begin
            cw <= span2 ? {q_neg[COORD_W-2:0], 1'b0} : q_neg;
          end else begin
            cw <= span2 ? {q_pos[COORD_W-2:0], 1'b0} : q_pos;
          end
        end
      end
      S_HEIGHT_DIV: begin
        if (div_rsp.done) begin
          ch <= h_diff[COORD_W] ? q_neg : q_pos;
        end
      end
      S_MAC_T: vt <= mac;
      S_MAC_L: vl <= mac;
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  // Checks
  a_accept_to_grid: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_GRID))
    else $error("accepted request did not start the grid search");

  a_grid_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRID) |-> ((rows <= MAX_DIM) && (cols <= rows)))
    else $error("grid grew outside its bounds");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |->
      ((state == S_SLOT_DIV) || (state == S_WIDTH_DIV) || (state == S_HEIGHT_DIV)))
    else $error("divider finished outside a divide step");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FINISH))
    else $error("result word appeared without a finish step");

endmodule
